/* src/assert_macros.svh */
// Assertion macros shared by the camera ray direction RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error(msg);

`endif

/* src/cprd_pkg.sv */
// Types and fixed widths of the camera ray direction block.
// No dependencies.
package cprd_pkg;

  localparam int unsigned PIX_W     = 12;
  localparam int unsigned RES_W     = 13;
  localparam int unsigned FIX_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned MAG_W     = 13;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned WNUM_W    = 38;
  localparam int unsigned NORM_W    = 30;
  localparam int unsigned SQ_W      = 2 * NORM_W;
  localparam int unsigned SUMSQ_W   = SQ_W + 2;
  localparam int unsigned ROOT_W    = SUMSQ_W / 2;
  localparam int unsigned UNIT_SH   = 14;
  localparam int unsigned NNUM_W    = NORM_W + UNIT_SH + 1;
  localparam int unsigned DIR_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT,
    REG_UP,
    REG_FORWARD,
    REG_FOCAL,
    REG_SCALE,
    REG_ASPECT,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic             nx_neg;
    logic [MAG_W-1:0] nx_mag;
    logic             ny_neg;
    logic [MAG_W-1:0] ny_mag;
    logic             w_zero;
    logic             h_zero;
  } pix_item_t;

endpackage

/* src/cprd_front.sv */
// Front end: accepts pixel transactions and classifies screen offsets.
// Depends on cprd_pkg.
module cprd_front import cprd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PIX_W-1:0] pixel_x_i,
  input  logic [PIX_W-1:0] pixel_y_i,
  input  logic [RES_W-1:0] width_i,
  input  logic [RES_W-1:0] height_i,
  input  logic             q_full_i,
  output logic             busy_o,
  output logic             push_o,
  output pix_item_t        item_o
);

  logic             vld_q, vld_d;
  pix_item_t        item_q, item_d;
  logic             accept;
  logic signed [RES_W+1:0] dx, dy;

  assign busy_o = vld_q && q_full_i;
  assign push_o = vld_q && !q_full_i;
  assign accept = start_i && !busy_o;
  assign item_o = item_q;

  always_comb begin
    dx = $signed({2'b00, pixel_x_i, 1'b1}) - $signed({2'b00, width_i});
    dy = $signed({2'b00, height_i}) - $signed({2'b00, pixel_y_i, 1'b1});
    item_d.nx_neg = dx[RES_W+1];
    item_d.nx_mag = dx[RES_W+1] ? MAG_W'(-dx) : MAG_W'(dx);
    item_d.ny_neg = dy[RES_W+1];
    item_d.ny_mag = dy[RES_W+1] ? MAG_W'(-dy) : MAG_W'(dy);
    item_d.w_zero = (width_i == '0);
    item_d.h_zero = (height_i == '0);
    vld_d = accept ? 1'b1 : (push_o ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* src/cprd_fifo.sv */
// Two-entry queue between the front end and the back end.
// Depends on cprd_pkg.
module cprd_fifo import cprd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pix_item_t data_i,
  input  logic      pop_i,
  output pix_item_t data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  pix_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* src/cprd_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module cprd_div #(
  parameter int unsigned NW = 38,
  parameter int unsigned DW = 13,
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic          vld_p;
    logic [NW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [DW-1:0] rem_p;
    logic [NW-1:0] quo_p;
    logic [SW-1:0] side_p;
    logic [DW:0]   trial, diff;
    logic          take;

    if (s == 0) begin : g_first
      assign vld_p  = vld_i;
      assign num_p  = num_i;
      assign den_p  = den_i;
      assign rem_p  = '0;
      assign quo_p  = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign num_p  = num_q[s-1];
      assign den_p  = den_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign quo_p  = quo_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign trial = {rem_p, num_p[NW-1-s]};
    assign take  = (trial >= {1'b0, den_p});
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s]  <= num_p;
      den_q[s]  <= den_p;
      rem_q[s]  <= take ? diff[DW-1:0] : trial[DW-1:0];
      quo_q[s]  <= {quo_p[NW-2:0], take};
      side_q[s] <= side_p;
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo_o  = quo_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule

/* src/cprd_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
// No dependencies.
module cprd_sqrt #(
  parameter int unsigned IW = 62,
  parameter int unsigned SW = 94
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [IW-1:0]   val_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [IW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned N  = IW / 2;
  localparam int unsigned RW = N + 2;

  logic          vld_q  [N];
  logic [IW-1:0] val_q  [N];
  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];
  logic [SW-1:0] side_q [N];

  for (genvar s = 0; s < N; s++) begin : g_st
    logic          vld_p;
    logic [IW-1:0] val_p;
    logic [RW-1:0] rem_p;
    logic [N-1:0]  root_p;
    logic [SW-1:0] side_p;
    logic [RW+1:0] trial, tst, diff;
    logic          take;

    if (s == 0) begin : g_first
      assign vld_p  = vld_i;
      assign val_p  = val_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign val_p  = val_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign trial = {rem_p, val_p[IW-1-2*s -: 2]};
    assign tst   = {RW'(root_p), 2'b01};
    assign take  = (trial >= tst);
    assign diff  = trial - tst;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[s]  <= val_p;
      rem_q[s]  <= take ? diff[RW-1:0] : trial[RW-1:0];
      root_q[s] <= {root_p[N-2:0], take};
      side_q[s] <= side_p;
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = root_q[N-1];
  assign side_o = side_q[N-1];

endmodule

/* src/cprd_back.sv */
// Back end: screen weights, camera basis sum, normalization and result register.
// Depends on cprd_pkg, cprd_div and cprd_sqrt.
module cprd_back import cprd_pkg::*; #(
  parameter int unsigned CW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_vld_i,
  input  pix_item_t               item_i,
  input  logic [3*CW-1:0]         right_i,
  input  logic [3*CW-1:0]         up_i,
  input  logic [3*CW-1:0]         forward_i,
  input  logic [FIX_W-1:0]        focal_i,
  input  logic [FIX_W-1:0]        scale_i,
  input  logic [FIX_W-1:0]        aspect_i,
  input  logic [RES_W-1:0]        width_i,
  input  logic [RES_W-1:0]        height_i,
  output logic                    done_o,
  output logic signed [DIR_W-1:0] dir_x_o,
  output logic signed [DIR_W-1:0] dir_y_o,
  output logic signed [DIR_W-1:0] dir_z_o,
  output logic                    zero_length_o
);

  localparam int unsigned PW   = CW + WEIGHT_W;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned MW   = SUMW - 1;
  localparam int unsigned SHW  = $clog2(MW - 28);
  localparam int unsigned XW   = MAG_W + 2 * FIX_W;
  localparam int unsigned YW   = MAG_W + FIX_W;
  localparam int unsigned SIDE_W = 3 * NORM_W + 4;

  function automatic logic signed [WEIGHT_W-1:0] to_weight(
    input logic [WNUM_W-1:0] q,
    input logic              neg,
    input logic              zero
  );
    logic [WEIGHT_W-2:0] m;
    m = (|q[WNUM_W-1:WEIGHT_W-1]) ? '1 : q[WEIGHT_W-2:0];
    if (zero) begin
      return '0;
    end
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // stage 1: scaled numerators
  logic [2*FIX_W-1:0] sa_q;
  logic               s1_vld_q;
  logic [WNUM_W-1:0]  s1_xn_q, s1_yn_q;
  logic [1:0]         s1_xs_q, s1_ys_q;
  logic [XW-1:0]      px;
  logic [XW:0]        pxr;
  logic [YW-1:0]      py;
  logic [YW+4:0]      pyr;

  always_comb begin
    px  = XW'(item_i.nx_mag * sa_q);
    pxr = (XW+1)'(px) + (XW+1)'({width_i, 7'b0});
    py  = YW'(item_i.ny_mag) * YW'(scale_i);
    pyr = {1'b0, py, 4'b0} + (YW+5)'(height_i[RES_W-1:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= item_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q    <= scale_i * aspect_i;
    s1_xn_q <= pxr[XW:8];
    s1_yn_q <= WNUM_W'(pyr);
    s1_xs_q <= {item_i.nx_neg, item_i.w_zero};
    s1_ys_q <= {item_i.ny_neg, item_i.h_zero};
  end

  logic              dx_vld, dy_vld;
  logic [WNUM_W-1:0] qx, qy;
  logic [1:0]        xs, ys;

  cprd_div #(.NW(WNUM_W), .DW(RES_W), .SW(2)) u_div_x (
    .clk_i, .rst_ni, .vld_i(s1_vld_q), .num_i(s1_xn_q), .den_i(width_i),
    .side_i(s1_xs_q), .vld_o(dx_vld), .quo_o(qx), .side_o(xs)
  );

  cprd_div #(.NW(WNUM_W), .DW(RES_W), .SW(2)) u_div_y (
    .clk_i, .rst_ni, .vld_i(s1_vld_q), .num_i(s1_yn_q), .den_i(height_i),
    .side_i(s1_ys_q), .vld_o(dy_vld), .quo_o(qy), .side_o(ys)
  );

  // stage 2: saturated signed weights
  logic                       s2_vld_q;
  logic signed [WEIGHT_W-1:0] s2_sx_q, s2_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= dx_vld && dy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sx_q <= to_weight(qx, xs[1], xs[0]);
    s2_sy_q <= to_weight(qy, ys[1], ys[0]);
  end

  // stage 3: basis products
  logic                       s3_vld_q;
  logic signed [PW-1:0]       s3_p_q [3][3];
  logic signed [WEIGHT_W-1:0] sf;

  assign sf = $signed({8'b0, focal_i, 8'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      s3_p_q[c][0] <= $signed(right_i[c*CW +: CW]) * s2_sx_q;
      s3_p_q[c][1] <= $signed(up_i[c*CW +: CW]) * s2_sy_q;
      s3_p_q[c][2] <= $signed(forward_i[c*CW +: CW]) * sf;
    end
  end

  // stage 4: sums to sign and magnitude
  logic                   s4_vld_q;
  logic [MW-1:0]          s4_mag_q [3];
  logic [2:0]             s4_neg_q;
  logic signed [SUMW-1:0] tsum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tsum[c] = SUMW'(s3_p_q[c][0]) + SUMW'(s3_p_q[c][1]) + SUMW'(s3_p_q[c][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      s4_neg_q[c] <= tsum[c][SUMW-1];
      s4_mag_q[c] <= tsum[c][SUMW-1] ? MW'(-tsum[c]) : MW'(tsum[c]);
    end
  end

  // stage 5: common shift amount
  logic           s5_vld_q, s5_zero_q;
  logic [MW-1:0]  s5_mag_q [3];
  logic [2:0]     s5_neg_q;
  logic [SHW-1:0] s5_sh_q, sh;
  logic [MW-1:0]  any_mag;

  always_comb begin
    any_mag = s4_mag_q[0] | s4_mag_q[1] | s4_mag_q[2];
    sh = '0;
    for (int i = NORM_W; i < MW; i++) begin
      if (any_mag[i]) begin
        sh = SHW'(i - (NORM_W - 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_mag_q  <= s4_mag_q;
    s5_neg_q  <= s4_neg_q;
    s5_sh_q   <= sh;
    s5_zero_q <= (any_mag == '0);
  end

  // stage 6: shift
  logic              s6_vld_q, s6_zero_q;
  logic [NORM_W-1:0] s6_m_q [3];
  logic [2:0]        s6_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      s6_m_q[c] <= NORM_W'(s5_mag_q[c] >> s5_sh_q);
    end
    s6_neg_q  <= s5_neg_q;
    s6_zero_q <= s5_zero_q;
  end

  // stage 7: squares
  logic              s7_vld_q, s7_zero_q;
  logic [NORM_W-1:0] s7_m_q [3];
  logic [SQ_W-1:0]   s7_sq_q [3];
  logic [2:0]        s7_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      s7_sq_q[c] <= SQ_W'(s6_m_q[c] * s6_m_q[c]);
    end
    s7_m_q    <= s6_m_q;
    s7_neg_q  <= s6_neg_q;
    s7_zero_q <= s6_zero_q;
  end

  // stage 8: sum of squares
  logic               s8_vld_q;
  logic [SUMSQ_W-1:0] s8_sum_q;
  logic [SIDE_W-1:0]  s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_sum_q  <= SUMSQ_W'(s7_sq_q[0]) + SUMSQ_W'(s7_sq_q[1]) + SUMSQ_W'(s7_sq_q[2]);
    s8_side_q <= {s7_m_q[2], s7_m_q[1], s7_m_q[0], s7_neg_q, s7_zero_q};
  end

  logic              sq_vld;
  logic [ROOT_W-1:0] root;
  logic [SIDE_W-1:0] sq_side;

  cprd_sqrt #(.IW(SUMSQ_W), .SW(SIDE_W)) u_sqrt (
    .clk_i, .rst_ni, .vld_i(s8_vld_q), .val_i(s8_sum_q), .side_i(s8_side_q),
    .vld_o(sq_vld), .root_o(root), .side_o(sq_side)
  );

  // stage 9: division operands
  logic              s9_vld_q, s9_zero_q;
  logic [NNUM_W-1:0] s9_num_q [3];
  logic [ROOT_W-1:0] s9_len_q, len;
  logic [2:0]        s9_neg_q;
  logic [NORM_W-1:0] sm [3];

  always_comb begin
    len = (root == '0) ? ROOT_W'(1) : root;
    for (int c = 0; c < 3; c++) begin
      sm[c] = sq_side[4 + c*NORM_W +: NORM_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else begin
      s9_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      s9_num_q[c] <= {1'b0, sm[c], UNIT_SH'(0)} + NNUM_W'(len[ROOT_W-1:1]);
    end
    s9_len_q  <= len;
    s9_neg_q  <= sq_side[3:1];
    s9_zero_q <= sq_side[0];
  end

  logic [2:0]        nd_vld;
  logic [NNUM_W-1:0] nq [3];
  logic [1:0]        n0_side;
  logic              n1_side, n2_side;

  cprd_div #(.NW(NNUM_W), .DW(ROOT_W), .SW(2)) u_div_n0 (
    .clk_i, .rst_ni, .vld_i(s9_vld_q), .num_i(s9_num_q[0]), .den_i(s9_len_q),
    .side_i({s9_neg_q[0], s9_zero_q}), .vld_o(nd_vld[0]), .quo_o(nq[0]),
    .side_o(n0_side)
  );

  cprd_div #(.NW(NNUM_W), .DW(ROOT_W), .SW(1)) u_div_n1 (
    .clk_i, .rst_ni, .vld_i(s9_vld_q), .num_i(s9_num_q[1]), .den_i(s9_len_q),
    .side_i(s9_neg_q[1]), .vld_o(nd_vld[1]), .quo_o(nq[1]), .side_o(n1_side)
  );

  cprd_div #(.NW(NNUM_W), .DW(ROOT_W), .SW(1)) u_div_n2 (
    .clk_i, .rst_ni, .vld_i(s9_vld_q), .num_i(s9_num_q[2]), .den_i(s9_len_q),
    .side_i(s9_neg_q[2]), .vld_o(nd_vld[2]), .quo_o(nq[2]), .side_o(n2_side)
  );

  // result register
  logic                    done_q, zl_q;
  logic signed [DIR_W-1:0] dir_q [3];
  logic signed [DIR_W-1:0] dir_d [3];
  logic [2:0]              nneg;

  always_comb begin
    nneg = {n2_side, n1_side, n0_side[1]};
    for (int c = 0; c < 3; c++) begin
      if (n0_side[0]) begin
        dir_d[c] = '0;
      end else if (nneg[c]) begin
        dir_d[c] = -$signed(nq[c][DIR_W-1:0]);
      end else begin
        dir_d[c] = $signed(nq[c][DIR_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= &nd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q <= dir_d;
    zl_q  <= n0_side[0];
  end

  assign done_o        = done_q;
  assign dir_x_o       = dir_q[0];
  assign dir_y_o       = dir_q[1];
  assign dir_z_o       = dir_q[2];
  assign zero_length_o = zl_q;

endmodule

/* src/camera_primary_ray_direction_top.sv */
// Pinhole camera primary ray direction: pixel in, unit Q1.14 direction out.
// The path from accepted start to done_o runs through the weight dividers (38 stages),
// the root pipeline (31) and the norm dividers (45).
// Throughput: one pixel per cycle; every unit is fully pipelined, busy_o stays low.
// Reset: asynchronous active low; clears all valid flags and loads the camera defaults.
`include "assert_macros.svh"
module camera_primary_ray_direction_top import cprd_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [PIX_W-1:0]             pixel_x_i,
  input  logic [PIX_W-1:0]             pixel_y_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [3*COMPONENT_WIDTH-1:0] cfg_data_i,
  output logic                         done_o,
  output logic signed [DIR_W-1:0]      dir_x_o,
  output logic signed [DIR_W-1:0]      dir_y_o,
  output logic signed [DIR_W-1:0]      dir_z_o,
  output logic                         zero_length_o
);

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned VW = 3 * CW;
  localparam logic [VW-1:0] ONE = VW'(1) << (CW - 2);

  logic [VW-1:0]    right_q, up_q, forward_q;
  logic [FIX_W-1:0] focal_q, scale_q, aspect_q;
  logic [RES_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q   <= ONE;
      up_q      <= ONE << CW;
      forward_q <= ONE << (2 * CW);
      focal_q   <= FIX_W'(256);
      scale_q   <= FIX_W'(4096);
      aspect_q  <= FIX_W'(4096);
      width_q   <= RES_W'(640);
      height_q  <= RES_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RIGHT:   right_q   <= cfg_data_i;
        REG_UP:      up_q      <= cfg_data_i;
        REG_FORWARD: forward_q <= cfg_data_i;
        REG_FOCAL:   focal_q   <= cfg_data_i[FIX_W-1:0];
        REG_SCALE:   scale_q   <= cfg_data_i[FIX_W-1:0];
        REG_ASPECT:  aspect_q  <= cfg_data_i[FIX_W-1:0];
        REG_WIDTH:   width_q   <= cfg_data_i[RES_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[RES_W-1:0];
        default: ;
      endcase
    end
  end

  logic      q_full, q_empty, push;
  pix_item_t f_item, b_item;

  cprd_front u_front (
    .clk_i, .rst_ni, .start_i, .pixel_x_i, .pixel_y_i,
    .width_i(width_q), .height_i(height_q), .q_full_i(q_full),
    .busy_o, .push_o(push), .item_o(f_item)
  );

  cprd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_item), .pop_i(!q_empty),
    .data_o(b_item), .empty_o(q_empty), .full_o(q_full)
  );

  cprd_back #(.CW(CW)) u_back (
    .clk_i, .rst_ni, .item_vld_i(!q_empty), .item_i(b_item),
    .right_i(right_q), .up_i(up_q), .forward_i(forward_q),
    .focal_i(focal_q), .scale_i(scale_q), .aspect_i(aspect_q),
    .width_i(width_q), .height_i(height_q),
    .done_o, .dir_x_o, .dir_y_o, .dir_z_o, .zero_length_o
  );

  `ASSERT_IMPLIES(a_zero_dir, done_o && zero_length_o, dir_x_o == '0 && dir_y_o == '0 && dir_z_o == '0, "zero length with nonzero direction")
  `ASSERT_IMPLIES(a_unit_x, done_o, dir_x_o <= 16'sd16384 && dir_x_o >= -16'sd16384, "dir_x beyond unit")
  `ASSERT_IMPLIES(a_unit_z, done_o, dir_z_o <= 16'sd16384 && dir_z_o >= -16'sd16384, "dir_z beyond unit")
  `ASSERT_NEXT(a_bad_index, cfg_we_i && cfg_index_i > REG_HEIGHT, width_q == $past(width_q) && height_q == $past(height_q), "unknown index changed a register")

endmodule
